>>> hdl/sts_pkg.sv
// shared types and constants for the sinh taylor series pipeline
// used by every module of the block; depends on nothing
`default_nettype none
package sts_pkg;
    localparam int unsigned FRAC_W   = 20;
    localparam int unsigned ARG_W    = 25;
    localparam int unsigned MAG_W    = 24;
    localparam int unsigned TOL_W    = 20;
    localparam int unsigned SUM_W    = 32;
    localparam int unsigned CNT_OUT_W = 6;
    // term magnitude stays below 512.0 for |x| up to 8.0
    localparam int unsigned TERM_W   = 29;
    localparam int unsigned X2_W     = 27;
    // term * x2 >> 20
    localparam int unsigned V_W      = 36;
    localparam int unsigned RECIP_W  = 34;
    localparam int unsigned K_W      = 15;
    localparam int unsigned CNT_W    = 7;
    localparam int unsigned MAX_TERMS_DEF = 32;
    localparam logic [MAG_W-1:0] ARG_LIMIT = MAG_W'(8388608);
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1024);

    typedef struct packed {
        logic              neg;
        logic [X2_W-1:0]   x2;
        logic [TERM_W-1:0] term;
        logic [SUM_W-1:0]  sum;
        logic [CNT_W-1:0]  count;
        logic              done;
    } item_t;
endpackage
`default_nettype wire

>>> hdl/sts_front.sv
// input stage: magnitude, clamp and x squared
// depends on sts_pkg
`default_nettype none
module sts_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         adv,
    input  wire logic                         in_valid,
    input  wire logic signed [sts_pkg::ARG_W-1:0] argument,
    output logic                              out_valid,
    output sts_pkg::item_t                    out_item
);
    logic                       neg;
    logic [sts_pkg::ARG_W-1:0]  raw_mag;
    logic [sts_pkg::MAG_W-1:0]  mag;
    logic [2*sts_pkg::MAG_W-1:0] sq;
    sts_pkg::item_t             item_next;
    sts_pkg::item_t             item_reg;
    logic                       valid_reg;

    always_comb
    begin
        neg     = argument[sts_pkg::ARG_W-1];
        raw_mag = neg ? (~argument + 1'b1) : argument;
        if (raw_mag > {1'b0, sts_pkg::ARG_LIMIT})
            mag = sts_pkg::ARG_LIMIT;
        else
            mag = raw_mag[sts_pkg::MAG_W-1:0];
        sq = mag * mag;
        item_next.neg   = neg;
        item_next.x2    = sq[sts_pkg::FRAC_W +: sts_pkg::X2_W];
        item_next.term  = sts_pkg::TERM_W'(mag);
        item_next.sum   = '0;
        item_next.count = '0;
        item_next.done  = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
endmodule
`default_nettype wire

>>> hdl/sts_term.sv
// one series term: add to sum, then next term = term * x2 / (k << 20), six stages
// depends on sts_pkg
`default_nettype none
module sts_term #(
    parameter int unsigned IDX = 1
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        adv,
    input  wire logic [sts_pkg::TOL_W-1:0]   tolerance,
    input  wire logic                        in_valid,
    input  sts_pkg::item_t                   in_item,
    output logic                             out_valid,
    output sts_pkg::item_t                   out_item
);
    localparam int unsigned K_VAL = (2 * IDX) * (2 * IDX + 1);
    localparam logic [sts_pkg::K_W-1:0] K = sts_pkg::K_W'(K_VAL);
    localparam logic [sts_pkg::RECIP_W-1:0] RECIP =
        sts_pkg::RECIP_W'((64'd1 << sts_pkg::V_W) / K_VAL);
    localparam int unsigned LO_W = 15;
    localparam int unsigned HI_W = sts_pkg::TERM_W - LO_W;
    localparam int unsigned VH_W = sts_pkg::V_W / 2;
    localparam int unsigned RH_W = sts_pkg::RECIP_W / 2;
    localparam int unsigned P_W  = sts_pkg::TERM_W + sts_pkg::X2_W;
    localparam int unsigned T_W  = sts_pkg::V_W + sts_pkg::RECIP_W;

    logic [5:0]      valid_reg;
    sts_pkg::item_t  it1_reg, it2_reg, it3_reg, it4_reg, it5_reg, it6_reg;
    sts_pkg::item_t  it1_next, it6_next;
    logic            take;
    logic [LO_W+sts_pkg::X2_W-1:0] pa_reg;
    logic [HI_W+sts_pkg::X2_W-1:0] pb_reg;
    logic [P_W-1:0]  prod_full;
    logic [sts_pkg::V_W-1:0] v2_reg, v3_reg, v4_reg, v5_reg;
    logic [VH_W+RH_W-1:0]    m0_reg, m1_reg, m2_reg, m3_reg;
    logic [T_W-1:0]          tot;
    logic [sts_pkg::TERM_W-1:0] q4_reg, q5_reg;
    logic [sts_pkg::V_W-1:0] qk5_reg;
    logic [sts_pkg::V_W-1:0] rem;
    logic [sts_pkg::TERM_W-1:0] q_fix;

    always_comb
    begin
        take     = !in_item.done && (in_item.term >= sts_pkg::TERM_W'(tolerance));
        it1_next = in_item;
        if (take)
        begin
            it1_next.sum   = in_item.sum + sts_pkg::SUM_W'(in_item.term);
            it1_next.count = in_item.count + 1'b1;
        end
        else
            it1_next.done = 1'b1;
    end

    assign prod_full = (P_W'(pb_reg) << LO_W) + P_W'(pa_reg);
    assign tot = T_W'(m0_reg) + (T_W'(m1_reg) << RH_W) + (T_W'(m2_reg) << VH_W)
               + (T_W'(m3_reg) << (VH_W + RH_W));

    always_comb
    begin
        rem      = v5_reg - qk5_reg;
        q_fix    = (rem >= sts_pkg::V_W'(K)) ? q5_reg + 1'b1 : q5_reg;
        it6_next = it5_reg;
        // finished items keep the term that fell below tolerance
        if (!it5_reg.done)
            it6_next.term = q_fix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[4:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it1_reg <= it1_next;
            pa_reg  <= in_item.term[LO_W-1:0] * in_item.x2;
            pb_reg  <= in_item.term[sts_pkg::TERM_W-1:LO_W] * in_item.x2;
            it2_reg <= it1_reg;
            v2_reg  <= prod_full[sts_pkg::FRAC_W +: sts_pkg::V_W];
            it3_reg <= it2_reg;
            v3_reg  <= v2_reg;
            m0_reg  <= v2_reg[VH_W-1:0] * RECIP[RH_W-1:0];
            m1_reg  <= v2_reg[VH_W-1:0] * RECIP[sts_pkg::RECIP_W-1:RH_W];
            m2_reg  <= v2_reg[sts_pkg::V_W-1:VH_W] * RECIP[RH_W-1:0];
            m3_reg  <= v2_reg[sts_pkg::V_W-1:VH_W] * RECIP[sts_pkg::RECIP_W-1:RH_W];
            it4_reg <= it3_reg;
            v4_reg  <= v3_reg;
            q4_reg  <= tot[sts_pkg::V_W +: sts_pkg::TERM_W];
            it5_reg <= it4_reg;
            v5_reg  <= v4_reg;
            q5_reg  <= q4_reg;
            qk5_reg <= sts_pkg::V_W'(q4_reg) * sts_pkg::V_W'(K);
            it6_reg <= it6_next;
        end
    end

    assign out_valid = valid_reg[5];
    assign out_item  = it6_reg;
endmodule
`default_nettype wire

>>> hdl/sts_back.sv
// output stage: cap flag, saturation, sign and count clamp
// depends on sts_pkg
`default_nettype none
module sts_back #(
    parameter int unsigned MAX_TERMS = sts_pkg::MAX_TERMS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          adv,
    input  wire logic [sts_pkg::TOL_W-1:0]     tolerance,
    input  wire logic                          in_valid,
    input  sts_pkg::item_t                     in_item,
    output logic                               out_valid,
    output logic signed [sts_pkg::SUM_W-1:0]   series_sum,
    output logic [sts_pkg::CNT_OUT_W-1:0]      terms_added,
    output logic                               cap_reached
);
    localparam logic [sts_pkg::SUM_W-1:0] POS_MAX = {1'b0, {(sts_pkg::SUM_W-1){1'b1}}};
    localparam logic [sts_pkg::SUM_W-1:0] NEG_MAX = {1'b1, {(sts_pkg::SUM_W-1){1'b0}}};
    localparam logic [sts_pkg::CNT_W-1:0] CNT_SAT = {1'b0, {(sts_pkg::CNT_W-1){1'b1}}};

    logic                          valid_reg;
    logic [sts_pkg::SUM_W-1:0]     sum_next, sum_reg;
    logic [sts_pkg::CNT_OUT_W-1:0] cnt_next, cnt_reg;
    logic                          cap_next, cap_reg;
    logic [sts_pkg::SUM_W-1:0]     mag;

    always_comb
    begin
        if (in_item.neg)
            mag = (in_item.sum > NEG_MAX) ? NEG_MAX : in_item.sum;
        else
            mag = (in_item.sum > POS_MAX) ? POS_MAX : in_item.sum;
        sum_next = in_item.neg ? (~mag + 1'b1) : mag;
        cnt_next = (in_item.count > CNT_SAT) ? sts_pkg::CNT_OUT_W'(CNT_SAT)
                                             : in_item.count[sts_pkg::CNT_OUT_W-1:0];
        cap_next = in_item.term >= sts_pkg::TERM_W'(tolerance);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
            cap_reg <= cap_next;
        end
    end

    assign out_valid   = valid_reg;
    assign series_sum  = sum_reg;
    assign terms_added = cnt_reg;
    assign cap_reached = cap_reg;

    // cap flag only after every term unit added its term
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && cap_reg |->
            32'(cnt_reg) == ((MAX_TERMS > 63) ? 32'd63 : 32'(MAX_TERMS)))
    else $error("cap flag set with a short term count");
endmodule
`default_nettype wire

>>> hdl/sinh_taylor_series.sv
// top level of the sinh taylor series pipeline
// depends on sts_pkg, sts_front, sts_term and sts_back
//
//  channel   signals                                      direction
//  in        in_valid, in_ready, argument                 request in
//  out       out_valid, out_ready, series_sum,            request out
//            terms_added, cap_reached
//  cfg       cfg_we, cfg_wdata (tolerance)                write only
//
// each term unit has six stages: split multiply, shift,
// reciprocal multiply, sum, correction multiply,
// correction compare
// one request enters every cycle while the output side takes results
// reset clears all valid bits and loads tolerance with 1024
// a stall at the output freezes the whole pipeline; nothing is dropped
`default_nettype none
module sinh_taylor_series #(
    parameter int unsigned MAX_TERMS = sts_pkg::MAX_TERMS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic signed [sts_pkg::ARG_W-1:0]   argument,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [sts_pkg::SUM_W-1:0]        series_sum,
    output logic [sts_pkg::CNT_OUT_W-1:0]           terms_added,
    output logic                                    cap_reached,
    input  wire logic                               cfg_we,
    input  wire logic [sts_pkg::TOL_W-1:0]          cfg_wdata
);
    logic                       adv;
    logic [sts_pkg::TOL_W-1:0]  tolerance_reg;
    logic [sts_pkg::TOL_W-1:0]  tolerance_next;
    logic                       chain_valid [0:MAX_TERMS];
    sts_pkg::item_t             chain_item  [0:MAX_TERMS];

    // whole pipeline moves together; output register frees when taken
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    assign tolerance_next = cfg_we ? cfg_wdata : tolerance_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tolerance_reg <= sts_pkg::TOL_RESET;
        else
            tolerance_reg <= tolerance_next;
    end

    // magnitude, clamp to 8.0, x squared
    sts_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .argument  (argument),
        .out_valid (chain_valid[0]),
        .out_item  (chain_item[0])
    );

    // one term unit per series term, divisor fixed per unit
    genvar g;
    generate
        for (g = 0; g < MAX_TERMS; g++)
        begin : g_term
            sts_term #(
                .IDX (g + 1)
            ) u_term (
                .clk       (clk),
                .rst_n     (rst_n),
                .adv       (adv),
                .tolerance (tolerance_reg),
                .in_valid  (chain_valid[g]),
                .in_item   (chain_item[g]),
                .out_valid (chain_valid[g+1]),
                .out_item  (chain_item[g+1])
            );
        end
    endgenerate

    // saturate, apply sign, doubles as the output register
    sts_back #(
        .MAX_TERMS (MAX_TERMS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .tolerance   (tolerance_reg),
        .in_valid    (chain_valid[MAX_TERMS]),
        .in_item     (chain_item[MAX_TERMS]),
        .out_valid   (out_valid),
        .series_sum  (series_sum),
        .terms_added (terms_added),
        .cap_reached (cap_reached)
    );

    // a waiting result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(series_sum)
            && $stable(terms_added))
    else $error("result changed while stalled");

    // input is blocked only by a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
    else $error("input blocked without a stall");

    // count never passes the cap
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(terms_added) <= MAX_TERMS)
    else $error("term count beyond cap");
endmodule
`default_nettype wire
